>>> src/cbb_pkg.sv
// Shared constants, types and codes for the clipped box blur block.
// Used by every other file of the block except cbb_if.
package cbb_pkg;

    localparam int RADIUS      = 5;
    localparam int MAX_WIDTH   = 1024;
    localparam int STORE_DEPTH = 2 * RADIUS * (MAX_WIDTH + 1);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int WID_W  = 11;
    localparam int HGT_W  = 13;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = HGT_W - 1;
    localparam int POS_W  = WID_W + HGT_W;
    localparam int WIN_W  = $clog2(2 * RADIUS + 1);
    localparam int CNT_W  = $clog2(4 * RADIUS * RADIUS + 1);
    localparam int SUM_W  = $clog2(4 * RADIUS * RADIUS * 255 + 1);
    localparam int DIVC_W = $clog2(SUM_W + 1);
    localparam int PIX_W  = 24;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SETUP,
        B_READ,
        B_FLUSH,
        B_DIV,
        B_OUT
    } back_state_t;

    // one output pixel to be computed
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } wr_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
    } geom_t;

endpackage

>>> src/cbb_if.sv
// Channel interfaces of the clipped box blur block: pixel in, pixel out, config.
// Depends on nothing.
interface cbb_pix_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

interface cbb_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface cbb_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  addr;
    logic [12:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

>>> src/cbb_front.sv
// Front end: config registers, input acceptance, frame positions, store writes
// and output pixel scheduling. Depends on cbb_pkg and cbb_if.
module cbb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    cbb_pix_in_if.sink           pix_in,
    cbb_cfg_if.sink              cfg,
    output cbb_pkg::job_t        job,
    output logic                 job_push,
    input  logic                 q_full,
    input  logic                 last_done,
    output cbb_pkg::wr_t         wr,
    output cbb_pkg::geom_t       geom,
    output logic                 drain_wait
);

    logic [cbb_pkg::WID_W-1:0]  width_raw_reg;
    logic [cbb_pkg::HGT_W-1:0]  height_raw_reg;
    logic                       hold_reg;
    logic                       drain_reg;
    logic [cbb_pkg::POS_W-1:0]  total_reg;
    logic [cbb_pkg::POS_W-1:0]  lag_reg;
    logic [cbb_pkg::POS_W-1:0]  in_pos_reg;
    logic [cbb_pkg::POS_W-1:0]  out_pos_reg;
    logic [cbb_pkg::ADDR_W-1:0] in_addr_reg;
    logic [cbb_pkg::ADDR_W-1:0] out_addr_reg;
    logic [cbb_pkg::ROW_W-1:0]  out_row_reg;
    logic [cbb_pkg::COL_W-1:0]  out_col_reg;

    logic [cbb_pkg::WID_W-1:0]  w_eff;
    logic [cbb_pkg::HGT_W-1:0]  h_eff;
    logic                       accept;
    logic                       cfg_wr;
    logic                       take_px;
    logic [cbb_pkg::POS_W-1:0]  in_pos_next;
    logic                       emit;
    logic                       is_last;

    always_comb
    begin
        if (width_raw_reg == '0)
            w_eff = cbb_pkg::WID_W'(1);
        else if (width_raw_reg > cbb_pkg::WID_W'(cbb_pkg::MAX_WIDTH))
            w_eff = cbb_pkg::WID_W'(cbb_pkg::MAX_WIDTH);
        else
            w_eff = width_raw_reg;
        h_eff = (height_raw_reg == '0) ? cbb_pkg::HGT_W'(1) : height_raw_reg;
    end

    assign geom.width  = w_eff;
    assign geom.height = h_eff;

    assign cfg.ready    = 1'b1;
    assign cfg_wr       = cfg.valid;
    // a config write owns its edge; no pixel beat is taken alongside it
    assign pix_in.ready = !hold_reg && !drain_reg && !q_full && !cfg.valid;
    assign accept       = pix_in.valid && pix_in.ready;
    assign drain_wait   = drain_reg;

    always_comb
    begin
        take_px     = accept && (pix_in.opcode == cbb_pkg::OP_PIXEL) && (in_pos_reg < total_reg);
        in_pos_next = in_pos_reg + cbb_pkg::POS_W'(take_px);
        emit        = accept && ((in_pos_next >= total_reg) ||
                                 (in_pos_next >= out_pos_reg + lag_reg + cbb_pkg::POS_W'(1)));
        is_last     = (out_pos_reg + cbb_pkg::POS_W'(1)) >= total_reg;
    end

    assign job_push = emit;
    assign job.row  = out_row_reg;
    assign job.col  = out_col_reg;
    assign job.addr = out_addr_reg;
    assign job.last = is_last;

    assign wr.en   = take_px;
    assign wr.addr = in_addr_reg;
    assign wr.data = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

    // frame size and lag are registered from the effective width and height
    always_ff @(posedge clk)
    begin
        total_reg <= cbb_pkg::POS_W'(w_eff) * cbb_pkg::POS_W'(h_eff);
        lag_reg   <= cbb_pkg::POS_W'(cbb_pkg::RADIUS - 1) * cbb_pkg::POS_W'(w_eff)
                   + cbb_pkg::POS_W'(cbb_pkg::RADIUS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= cbb_pkg::WID_W'(1024);
            height_raw_reg <= cbb_pkg::HGT_W'(1024);
            hold_reg       <= 1'b1;
            drain_reg      <= 1'b0;
            in_pos_reg     <= '0;
            out_pos_reg    <= '0;
            in_addr_reg    <= '0;
            out_addr_reg   <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
        end
        else
        begin
            hold_reg <= 1'b0;
            if (last_done)
                drain_reg <= 1'b0;
            if (cfg_wr)
            begin
                unique case (cbb_pkg::reg_idx_t'(cfg.addr))
                    cbb_pkg::REG_WIDTH:  width_raw_reg  <= cfg.data[cbb_pkg::WID_W-1:0];
                    cbb_pkg::REG_HEIGHT: height_raw_reg <= cfg.data;
                    default: ;
                endcase
                hold_reg     <= 1'b1;
                in_pos_reg   <= '0;
                out_pos_reg  <= '0;
                in_addr_reg  <= '0;
                out_addr_reg <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
            end
            else if (accept)
            begin
                if (take_px)
                begin
                    in_pos_reg  <= in_pos_next;
                    in_addr_reg <= (in_addr_reg == cbb_pkg::ADDR_W'(cbb_pkg::STORE_DEPTH - 1))
                                   ? '0 : in_addr_reg + cbb_pkg::ADDR_W'(1);
                end
                if (emit)
                begin
                    if (is_last)
                    begin
                        drain_reg    <= 1'b1;
                        in_pos_reg   <= '0;
                        out_pos_reg  <= '0;
                        in_addr_reg  <= '0;
                        out_addr_reg <= '0;
                        out_row_reg  <= '0;
                        out_col_reg  <= '0;
                    end
                    else
                    begin
                        out_pos_reg  <= out_pos_reg + cbb_pkg::POS_W'(1);
                        out_addr_reg <= (out_addr_reg ==
                                         cbb_pkg::ADDR_W'(cbb_pkg::STORE_DEPTH - 1))
                                        ? '0 : out_addr_reg + cbb_pkg::ADDR_W'(1);
                        if (cbb_pkg::WID_W'(out_col_reg) == w_eff - cbb_pkg::WID_W'(1))
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + cbb_pkg::ROW_W'(1);
                        end
                        else
                            out_col_reg <= out_col_reg + cbb_pkg::COL_W'(1);
                    end
                end
            end
        end
    end

endmodule

>>> src/cbb_queue.sv
// Two-entry job queue between front and back end.
// Depends on cbb_pkg.
module cbb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cbb_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output cbb_pkg::job_t pop_job,
    output logic          not_empty
);

    cbb_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> src/cbb_back.sv
// Back end: pixel store, window walk, per-channel sums, serial divide, output stage.
// Depends on cbb_pkg and cbb_if.
module cbb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  cbb_pkg::job_t  job,
    input  logic           job_valid,
    output logic           job_pop,
    input  cbb_pkg::wr_t   wr,
    input  cbb_pkg::geom_t geom,
    cbb_pix_out_if.source  pix_out,
    output logic           last_done
);

    logic [cbb_pkg::PIX_W-1:0] store_mem [cbb_pkg::STORE_DEPTH];
    logic [cbb_pkg::PIX_W-1:0] rd_data_reg;
    logic                      rd_vld_reg;

    cbb_pkg::back_state_t       state_reg, state_next;
    cbb_pkg::job_t              job_reg;
    logic [cbb_pkg::WIN_W-1:0]  rows_reg, cols_reg, r_cnt_reg, c_cnt_reg;
    logic [cbb_pkg::ADDR_W-1:0] row_base_reg, cur_addr_reg;
    logic [cbb_pkg::CNT_W-1:0]  cnt_reg;
    logic [cbb_pkg::SUM_W-1:0]  sum_reg [3];
    logic [cbb_pkg::CNT_W-1:0]  rem_reg [3];
    logic [cbb_pkg::DIVC_W-1:0] div_cnt_reg;
    logic [7:0]                 out_reg [3];
    logic                       out_last_reg;

    // window setup
    logic [cbb_pkg::HGT_W-1:0]  x0, x1;
    logic [cbb_pkg::WID_W-1:0]  y0, y1;
    logic [cbb_pkg::WIN_W-1:0]  dr, dc, rows, cols;
    logic [cbb_pkg::ADDR_W:0]   off, base;
    logic [cbb_pkg::ADDR_W-1:0] next_row, next_col;
    logic                       walk_col_end, walk_end;

    always_comb
    begin
        x0 = (job_reg.row >= cbb_pkg::ROW_W'(cbb_pkg::RADIUS))
             ? cbb_pkg::HGT_W'(job_reg.row - cbb_pkg::ROW_W'(cbb_pkg::RADIUS)) : '0;
        x1 = cbb_pkg::HGT_W'(job_reg.row) + cbb_pkg::HGT_W'(cbb_pkg::RADIUS);
        if (x1 > geom.height)
            x1 = geom.height;
        y0 = (job_reg.col >= cbb_pkg::COL_W'(cbb_pkg::RADIUS))
             ? cbb_pkg::WID_W'(job_reg.col - cbb_pkg::COL_W'(cbb_pkg::RADIUS)) : '0;
        y1 = cbb_pkg::WID_W'(job_reg.col) + cbb_pkg::WID_W'(cbb_pkg::RADIUS);
        if (y1 > geom.width)
            y1 = geom.width;
        dr   = cbb_pkg::WIN_W'(cbb_pkg::HGT_W'(job_reg.row) - x0);
        dc   = cbb_pkg::WIN_W'(cbb_pkg::WID_W'(job_reg.col) - y0);
        rows = cbb_pkg::WIN_W'(x1 - x0);
        cols = cbb_pkg::WIN_W'(y1 - y0);
        off  = (cbb_pkg::ADDR_W+1)'(dr) * (cbb_pkg::ADDR_W+1)'(geom.width)
             + (cbb_pkg::ADDR_W+1)'(dc);
        // circular store: step back by the offset, wrap once
        if ({1'b0, job_reg.addr} >= off)
            base = {1'b0, job_reg.addr} - off;
        else
            base = {1'b0, job_reg.addr} + (cbb_pkg::ADDR_W+1)'(cbb_pkg::STORE_DEPTH) - off;

        next_row = ({1'b0, row_base_reg} + (cbb_pkg::ADDR_W+1)'(geom.width)
                    >= (cbb_pkg::ADDR_W+1)'(cbb_pkg::STORE_DEPTH))
                   ? cbb_pkg::ADDR_W'({1'b0, row_base_reg} + (cbb_pkg::ADDR_W+1)'(geom.width)
                                      - (cbb_pkg::ADDR_W+1)'(cbb_pkg::STORE_DEPTH))
                   : row_base_reg + cbb_pkg::ADDR_W'(geom.width);
        next_col = (cur_addr_reg == cbb_pkg::ADDR_W'(cbb_pkg::STORE_DEPTH - 1))
                   ? '0 : cur_addr_reg + cbb_pkg::ADDR_W'(1);
        walk_col_end = (c_cnt_reg == cols_reg - cbb_pkg::WIN_W'(1));
        walk_end     = walk_col_end && (r_cnt_reg == rows_reg - cbb_pkg::WIN_W'(1));
    end

    // store: written by the front end, read one entry per cycle during the walk
    always_ff @(posedge clk)
    begin
        if (wr.en)
            store_mem[wr.addr] <= wr.data;
        rd_data_reg <= store_mem[cur_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cbb_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        last_done  = 1'b0;
        unique case (state_reg)
            cbb_pkg::B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = cbb_pkg::B_SETUP;
                end
            end
            cbb_pkg::B_SETUP: state_next = cbb_pkg::B_READ;
            cbb_pkg::B_READ:
            begin
                if (walk_end)
                    state_next = cbb_pkg::B_FLUSH;
            end
            cbb_pkg::B_FLUSH: state_next = cbb_pkg::B_DIV;
            cbb_pkg::B_DIV:
            begin
                if (div_cnt_reg == cbb_pkg::DIVC_W'(1))
                    state_next = cbb_pkg::B_OUT;
            end
            cbb_pkg::B_OUT:
            begin
                if (pix_out.ready)
                begin
                    last_done  = out_last_reg;
                    state_next = cbb_pkg::B_IDLE;
                end
            end
            default: state_next = cbb_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= (state_reg == cbb_pkg::B_READ);
    end

    always_ff @(posedge clk)
    begin
        logic [cbb_pkg::CNT_W:0] t;
        case (state_reg)
            cbb_pkg::B_IDLE:
            begin
                if (job_valid)
                    job_reg <= job;
            end
            cbb_pkg::B_SETUP:
            begin
                rows_reg     <= rows;
                cols_reg     <= cols;
                r_cnt_reg    <= '0;
                c_cnt_reg    <= '0;
                row_base_reg <= cbb_pkg::ADDR_W'(base);
                cur_addr_reg <= cbb_pkg::ADDR_W'(base);
                cnt_reg      <= cbb_pkg::CNT_W'(rows) * cbb_pkg::CNT_W'(cols);
                out_last_reg <= job_reg.last;
                for (int k = 0; k < 3; k++)
                    sum_reg[k] <= '0;
            end
            cbb_pkg::B_READ:
            begin
                if (walk_col_end)
                begin
                    c_cnt_reg    <= '0;
                    r_cnt_reg    <= r_cnt_reg + cbb_pkg::WIN_W'(1);
                    row_base_reg <= next_row;
                    cur_addr_reg <= next_row;
                end
                else
                begin
                    c_cnt_reg    <= c_cnt_reg + cbb_pkg::WIN_W'(1);
                    cur_addr_reg <= next_col;
                end
            end
            cbb_pkg::B_FLUSH:
            begin
                div_cnt_reg <= cbb_pkg::DIVC_W'(cbb_pkg::SUM_W);
                for (int k = 0; k < 3; k++)
                    rem_reg[k] <= '0;
            end
            cbb_pkg::B_DIV:
            begin
                // restoring divide, one quotient bit per cycle, sum becomes quotient
                div_cnt_reg <= div_cnt_reg - cbb_pkg::DIVC_W'(1);
                for (int k = 0; k < 3; k++)
                begin
                    t = {rem_reg[k], sum_reg[k][cbb_pkg::SUM_W-1]};
                    if (t >= {1'b0, cnt_reg})
                    begin
                        rem_reg[k] <= cbb_pkg::CNT_W'(t - {1'b0, cnt_reg});
                        sum_reg[k] <= {sum_reg[k][cbb_pkg::SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k] <= cbb_pkg::CNT_W'(t);
                        sum_reg[k] <= {sum_reg[k][cbb_pkg::SUM_W-2:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase

        if (rd_vld_reg)
        begin
            sum_reg[0] <= sum_reg[0] + cbb_pkg::SUM_W'(rd_data_reg[23:16]);
            sum_reg[1] <= sum_reg[1] + cbb_pkg::SUM_W'(rd_data_reg[15:8]);
            sum_reg[2] <= sum_reg[2] + cbb_pkg::SUM_W'(rd_data_reg[7:0]);
        end

        if (state_reg == cbb_pkg::B_DIV && div_cnt_reg == cbb_pkg::DIVC_W'(1))
        begin
            // last quotient bit shifts in on this edge
            for (int k = 0; k < 3; k++)
            begin
                t = {rem_reg[k], sum_reg[k][cbb_pkg::SUM_W-1]};
                out_reg[k] <= {sum_reg[k][6:0], (t >= {1'b0, cnt_reg})};
            end
        end
    end

    assign pix_out.valid     = (state_reg == cbb_pkg::B_OUT);
    assign pix_out.red_out   = out_reg[0];
    assign pix_out.green_out = out_reg[1];
    assign pix_out.blue_out  = out_reg[2];
    assign pix_out.frame_end = out_last_reg;

endmodule

>>> src/clipped_box_blur_rgb_core.sv
// Top level of the clipped box blur: front end, job queue and back end.
// Depends on cbb_pkg, cbb_if, cbb_front, cbb_queue and cbb_back.
//
// Usage: RGB pixels enter on pix_in in raster order (opcode 0), drain beats
// (opcode 1) flush the tail of a frame. Each output pixel on pix_out is the
// truncated mean of its 10x10 window clipped to the frame; frame_end marks the
// last pixel. Output pixel n becomes due once input pixel n+4*width+4 is taken.
// Registers image_width (index 0) and image_height (index 1) are written on
// cfg; the user must write them only while the block is idle, which the block
// itself does not enforce; a write restarts the frame. Output pixels are
// computed one at a time: the single store read port walks the window, then
// the serial divider runs. Input beats that cause no output are taken one per
// cycle while the two-entry job queue has room and no config write is pending.
// Once the last job of a frame is queued, input waits until that pixel leaves.
// Reset: width and height return to 1024, positions to zero; the pixel store
// is not cleared. A stalled receiver holds the output beat and, through the
// queue, eventually the input side.
module clipped_box_blur_rgb_core (
    input  logic           clk,
    input  logic           rst_n,
    cbb_pix_in_if.sink     pix_in,
    cbb_pix_out_if.source  pix_out,
    cbb_cfg_if.sink        cfg
);

    cbb_pkg::job_t  push_job;
    cbb_pkg::job_t  pop_job;
    cbb_pkg::wr_t   wr;
    cbb_pkg::geom_t geom;
    logic           job_push;
    logic           q_full;
    logic           q_not_empty;
    logic           job_pop;
    logic           last_done;
    logic           drain_wait;

    cbb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .cfg        (cfg),
        .job        (push_job),
        .job_push   (job_push),
        .q_full     (q_full),
        .last_done  (last_done),
        .wr         (wr),
        .geom       (geom),
        .drain_wait (drain_wait)
    );

    cbb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (job_pop),
        .pop_job   (pop_job),
        .not_empty (q_not_empty)
    );

    cbb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (pop_job),
        .job_valid (q_not_empty),
        .job_pop   (job_pop),
        .wr        (wr),
        .geom      (geom),
        .pix_out   (pix_out),
        .last_done (last_done)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        drain_wait |-> !job_push)
        else $error("job scheduled while frame end is pending");

    a_drain_release: assert property (@(posedge clk) disable iff (!rst_n)
        last_done |=> !drain_wait)
        else $error("frame end delivered but input still held");
`endif

endmodule

>>> dv/tb_blur_if.sv
// Testbench note: the block's channel interfaces live in src/cbb_if.sv.
// This file holds small shared types of the testbench; depends on cbb_pkg.
package tb_blur_pkg;

    typedef struct packed {
        cbb_pkg::opcode_t op;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
    } pix_beat_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       fend;
    } blur_px_t;
endpackage

>>> dv/tb.sv
// Testbench top for clipped_box_blur_rgb_core: random and directed frames,
// a software blur predictor and an in-order output checker.
// Depends on cbb_pkg, cbb_if (src) and tb_blur_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    cbb_pix_in_if  pin ();
    cbb_pix_out_if pout ();
    cbb_cfg_if     cfgc ();

    clipped_box_blur_rgb_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pin),
        .pix_out (pout),
        .cfg     (cfgc)
    );

    // predictor state
    logic [23:0] pix_mem [cbb_pkg::STORE_DEPTH];
    int unsigned cur_w, cur_h;
    int unsigned in_pos, out_pos;

    tb_blur_pkg::pix_beat_t beat_q [$];
    tb_blur_pkg::blur_px_t  blur_q [$];
    int          n_err;
    longint      cyc;
    bit          rx_hold;
    bit          tx_run;
    bit          in_acc;
    int          burst_left;
    int          gap_left;
    bit          stall_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cyc = 0;
        in_acc = 1'b0;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > 3000000)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("tb: mismatch %s at cycle %0d", what, cyc);
        n_err++;
    endtask

    function automatic int unsigned eff_w(int unsigned v);
        if (v == 0) return 1;
        if (v > cbb_pkg::MAX_WIDTH) return cbb_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic int unsigned eff_h(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic tb_blur_pkg::blur_px_t window_mean(int unsigned q, int unsigned w,
                                                          int unsigned h);
        tb_blur_pkg::blur_px_t res;
        int          j, i;
        int unsigned sr, sg, sb, cnt;
        logic [23:0] px;
        j = q / w;
        i = q % w;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int x = j - cbb_pkg::RADIUS; x < j + cbb_pkg::RADIUS; x++)
        begin
            if (x < 0 || x >= int'(h))
                continue;
            for (int y = i - cbb_pkg::RADIUS; y < i + cbb_pkg::RADIUS; y++)
            begin
                if (y < 0 || y >= int'(w))
                    continue;
                px = pix_mem[(x * w + y) % cbb_pkg::STORE_DEPTH];
                sr += px[23:16];
                sg += px[15:8];
                sb += px[7:0];
                cnt++;
            end
        end
        if (cnt == 0)
            cnt = 1;
        res.r = 8'(sr / cnt);
        res.g = 8'(sg / cnt);
        res.b = 8'(sb / cnt);
        res.fend = 1'b0;
        return res;
    endfunction

    // one accepted input beat through the predictor
    task automatic blur_step(input tb_blur_pkg::pix_beat_t bt);
        int unsigned w, h, total, lag, q;
        tb_blur_pkg::blur_px_t res;
        w = eff_w(cur_w);
        h = eff_h(cur_h);
        total = w * h;
        lag = (cbb_pkg::RADIUS - 1) * w + (cbb_pkg::RADIUS - 1);
        if (bt.op == cbb_pkg::OP_PIXEL && in_pos < total)
        begin
            pix_mem[in_pos % cbb_pkg::STORE_DEPTH] = {bt.r, bt.g, bt.b};
            in_pos++;
        end
        q = out_pos;
        if (q >= total)
        begin
            in_pos = 0;
            out_pos = 0;
            return;
        end
        if (!(in_pos >= total || in_pos >= q + lag + 1))
            return;
        res = window_mean(q, w, h);
        if (q + 1 >= total)
        begin
            res.fend = 1'b1;
            in_pos = 0;
            out_pos = 0;
        end
        else
            out_pos = q + 1;
        blur_q.push_back(res);
    endtask

    // driver: bursts and gaps on the pixel channel; a beat stays until the
    // monitor has seen it accepted
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin.valid  <= 1'b0;
            pin.opcode <= cbb_pkg::OP_PIXEL;
            pin.red_in <= '0;
            pin.green_in <= '0;
            pin.blue_in <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (pin.valid && !in_acc)
                pin.valid <= 1'b1;
            else if (gap_left > 0 || !tx_run)
            begin
                pin.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else if (beat_q.size() > 0)
            begin
                pin.valid    <= 1'b1;
                pin.opcode   <= beat_q[0].op;
                pin.red_in   <= beat_q[0].r;
                pin.green_in <= beat_q[0].g;
                pin.blue_in  <= beat_q[0].b;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                pin.valid <= 1'b0;
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pout.ready <= 1'b0;
            stall_on <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 31) == 0)
                stall_on <= ~stall_on;
            pout.ready <= !rx_hold && !(stall_on && $urandom_range(0, 2) != 0);
        end
    end

    // monitor: predictor on input beats, checker on output beats
    always @(posedge clk)
    begin
        tb_blur_pkg::blur_px_t e;
        if (rst_n)
        begin
            in_acc = pin.valid && pin.ready;
            if (in_acc)
                blur_step(beat_q.pop_front());
            if (pout.valid && pout.ready)
            begin
                if (blur_q.size() == 0)
                    report("unexpected output beat");
                else
                begin
                    e = blur_q.pop_front();
                    if (pout.red_out !== e.r)
                        report($sformatf("red %0d exp %0d", pout.red_out, e.r));
                    if (pout.green_out !== e.g)
                        report($sformatf("green %0d exp %0d", pout.green_out, e.g));
                    if (pout.blue_out !== e.b)
                        report($sformatf("blue %0d exp %0d", pout.blue_out, e.b));
                    if (pout.frame_end !== e.fend)
                        report($sformatf("frame_end %0b exp %0b", pout.frame_end, e.fend));
                end
            end
        end
        else
            in_acc = 1'b0;
    end

    task automatic wait_idle();
        while (beat_q.size() != 0 || blur_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic reg_write(input cbb_pkg::reg_idx_t idx, input int unsigned val);
        @(negedge clk);
        cfgc.valid <= 1'b1;
        cfgc.addr  <= idx;
        cfgc.data  <= 13'(val);
        @(posedge clk);
        while (!cfgc.ready)
            @(posedge clk);
        @(negedge clk);
        cfgc.valid <= 1'b0;
        if (idx == cbb_pkg::REG_WIDTH)
            cur_w = val & 11'h7FF;
        else
            cur_h = val & 13'h1FFF;
        in_pos = 0;
        out_pos = 0;
    endtask

    function automatic tb_blur_pkg::pix_beat_t rand_px();
        tb_blur_pkg::pix_beat_t bt;
        bt.op = cbb_pkg::OP_PIXEL;
        bt.r = 8'($urandom);
        bt.g = 8'($urandom);
        bt.b = 8'($urandom);
        return bt;
    endfunction

    // one full frame; a few stray drains mid-frame, drains once all pixels are in
    task automatic queue_frame(input int unsigned w, input int unsigned h, input bit extremes);
        tb_blur_pkg::pix_beat_t bt;
        int unsigned n, lag, need;
        n = eff_w(w) * eff_h(h);
        lag = (cbb_pkg::RADIUS - 1) * eff_w(w) + (cbb_pkg::RADIUS - 1);
        for (int unsigned k = 0; k < n; k++)
        begin
            bt = rand_px();
            if (extremes)
            begin
                bt.r = (k % 2) ? 8'hFF : 8'h00;
                bt.g = (k % 3 == 0) ? 8'hFF : 8'h00;
                bt.b = 8'hFF - bt.r;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                bt.op = cbb_pkg::OP_DRAIN;
                beat_q.push_back(bt);
                bt = rand_px();
            end
            beat_q.push_back(bt);
        end
        // drain: pixels after completion also act as drains
        need = (n < lag) ? n : lag;
        for (int unsigned k = 0; k < need + 1; k++)
        begin
            bt = rand_px();
            bt.op = ($urandom_range(0, 3) == 0) ? cbb_pkg::OP_PIXEL : cbb_pkg::OP_DRAIN;
            if (k == need)
                bt.op = cbb_pkg::OP_DRAIN;
            beat_q.push_back(bt);
        end
    endtask

    initial
    begin
        int unsigned w, h;
        n_err = 0;
        rx_hold = 1'b0;
        tx_run = 1'b1;
        cfgc.valid = 1'b0;
        cfgc.addr = cbb_pkg::REG_WIDTH;
        cfgc.data = '0;
        cur_w = 1024;
        cur_h = 1024;
        in_pos = 0;
        out_pos = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme sizes and extreme pixel values
        reg_write(cbb_pkg::REG_WIDTH, 1);
        reg_write(cbb_pkg::REG_HEIGHT, 1);
        queue_frame(1, 1, 1);
        wait_idle();
        reg_write(cbb_pkg::REG_WIDTH, 0);
        reg_write(cbb_pkg::REG_HEIGHT, 0);
        queue_frame(0, 0, 1);
        wait_idle();
        reg_write(cbb_pkg::REG_WIDTH, 4);
        reg_write(cbb_pkg::REG_HEIGHT, 3);
        queue_frame(4, 3, 1);
        wait_idle();

        // long receiver hold-off while input keeps coming
        reg_write(cbb_pkg::REG_WIDTH, 3);
        reg_write(cbb_pkg::REG_HEIGHT, 5);
        queue_frame(3, 5, 0);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
        wait_idle();

        // sender pauses mid-frame until all results so far are back
        queue_frame(3, 5, 0);
        while (beat_q.size() > 8)
            @(posedge clk);
        tx_run = 1'b0;
        while (blur_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        tx_run = 1'b1;
        wait_idle();

        // random frames, mostly small
        for (int f = 0; f < 8; f++)
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            if (f == 1)
            begin
                w = 1;
                h = 20;
            end
            if (f == 3)
            begin
                w = 30;
                h = 1;
            end
            if (f == 5)
            begin
                w = 2047;      // clipped to MAX_WIDTH
                h = 3;
            end
            if (f == 7)
            begin
                w = 6;
                h = 8191;
            end
            reg_write(cbb_pkg::REG_WIDTH, w);
            reg_write(cbb_pkg::REG_HEIGHT, h);
            if (f == 5)
            begin
                // start of a clipped-width frame, then a restart by config write
                for (int k = 0; k < 30; k++)
                    beat_q.push_back(rand_px());
                wait_idle();
                reg_write(cbb_pkg::REG_WIDTH, 7);
                w = 7;
            end
            if (f == 7)
            begin
                // partial frame only, then a restart by config write
                for (int k = 0; k < 60; k++)
                    beat_q.push_back(rand_px());
                wait_idle();
                reg_write(cbb_pkg::REG_HEIGHT, 2);
                h = 2;
            end
            queue_frame(w, h, 0);
            wait_idle();
        end

        if (n_err == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
